### src/mdio22_pkg.sv
// Shared types and constants for the MDIO Clause 22 slave.
// Used by mdio22_core and mdio_clause22_slave.
package mdio22_pkg;

    localparam int unsigned ADDR_BITS = 5;
    localparam int unsigned DATA_BITS = 16;
    localparam int unsigned CNT_BITS  = 5;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_START = 4'd1,
        ST_OP1   = 4'd2,
        ST_OP2   = 4'd3,
        ST_TA1   = 4'd4,
        ST_TA2   = 4'd5,
        ST_PHYAD = 4'd6,
        ST_REGAD = 4'd7,
        ST_READ  = 4'd8,
        ST_WRITE = 4'd9
    } t_state;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_OP   = 2'd1,
        STAT_TA_ERR   = 2'd2,
        STAT_MISMATCH = 2'd3
    } t_status;

    localparam logic [0:0] CFG_PHY_ADDRESS = 1'b0;
    localparam logic [0:0] CFG_PHY_PRESENT = 1'b1;

    typedef struct packed {
        logic                 drive_enable;
        logic                 drive_bit;
        logic                 read_request;
        logic                 write_strobe;
        logic [ADDR_BITS-1:0] register_address;
        logic [DATA_BITS-1:0] write_data;
        t_status              status;
    } t_result;

endpackage

### src/mdio_clause22_slave.sv
// Top level of the MDIO Clause 22 slave: stream handshake, configuration
// registers and result register. Depends on mdio22_pkg and mdio22_core.
// The result of an MDC edge appears in the cycle after it is accepted.
// Throughput: one edge per cycle while the result register is free or being taken.
// Reset (synchronous, active low) returns the frame engine to idle, releases
// the line and clears both configuration registers.
module mdio_clause22_slave
    import mdio22_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mdio_bit [0], read_data [16:1], zero fill [23:17]
    input  logic [23:0] s_axis_tdata,
    // clock_edge [0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // drive_enable [0], drive_bit [1], read_request [2], write_strobe [3],
    // register_address [8:4], write_data [24:9], status [26:25], zero fill [31:27]
    output logic [31:0] m_axis_tdata
);

    logic [ADDR_BITS-1:0] r_phy_address;
    logic                 r_phy_present;
    logic                 r_out_valid;
    t_result              r_out;
    t_result              n_out;
    logic                 accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phy_address <= '0;
            r_phy_present <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PHY_ADDRESS: r_phy_address <= i_cfg_wdata;
                CFG_PHY_PRESENT: r_phy_present <= i_cfg_wdata[0];
                default:         r_phy_present <= r_phy_present;
            endcase
        end
    end

    mdio22_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_edge        (s_axis_tuser),
        .i_bit         (s_axis_tdata[0]),
        .i_read_data   (s_axis_tdata[DATA_BITS:1]),
        .i_phy_address (r_phy_address),
        .i_phy_present (r_phy_present),
        .o_result      (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.status, r_out.write_data, r_out.register_address,
                            r_out.write_strobe, r_out.read_request, r_out.drive_bit,
                            r_out.drive_enable};

endmodule

### src/mdio22_core.sv
// Frame state machine of the MDIO Clause 22 slave: holds the frame state
// and computes the result of one MDC edge. Depends on mdio22_pkg.
module mdio22_core
    import mdio22_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_edge,
    input  logic                 i_bit,
    input  logic [DATA_BITS-1:0] i_read_data,
    input  logic [ADDR_BITS-1:0] i_phy_address,
    input  logic                 i_phy_present,
    output t_result              o_result
);

    t_state               r_state,     n_state;
    logic [CNT_BITS-1:0]  r_cnt,       n_cnt;
    logic                 r_is_write,  n_is_write;
    logic [DATA_BITS-1:0] r_data,      n_data;
    logic [ADDR_BITS-1:0] r_phy,       n_phy;
    logic [ADDR_BITS-1:0] r_reg,       n_reg;
    logic                 r_drv,       n_drv;
    logic                 r_lvl,       n_lvl;
    logic                 rreq, wstb;
    t_status              status;
    logic                 addressed;

    assign addressed = i_phy_present && (r_phy == i_phy_address);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_is_write = r_is_write;
        n_data     = r_data;
        n_phy      = r_phy;
        n_reg      = r_reg;
        n_drv      = r_drv;
        n_lvl      = r_lvl;
        rreq       = 1'b0;
        wstb       = 1'b0;
        status     = STAT_OK;
        if (i_edge) begin
            unique case (r_state)
                ST_START: begin
                    n_state = i_bit ? ST_OP1 : ST_IDLE;
                end
                ST_OP1: begin
                    n_is_write = ~i_bit;
                    n_state    = ST_OP2;
                end
                ST_OP2: begin
                    if (i_bit == r_is_write) begin
                        n_phy   = '0;
                        n_cnt   = '0;
                        n_state = ST_PHYAD;
                    end else begin
                        status  = STAT_BAD_OP;
                        n_state = ST_IDLE;
                    end
                end
                ST_PHYAD: begin
                    n_phy = {r_phy[ADDR_BITS-2:0], i_bit};
                    n_cnt = r_cnt + 1'b1;
                    if (n_cnt >= CNT_BITS'(ADDR_BITS)) begin
                        n_cnt   = '0;
                        n_reg   = '0;
                        n_state = ST_REGAD;
                    end
                end
                ST_REGAD: begin
                    n_reg = {r_reg[ADDR_BITS-2:0], i_bit};
                    n_cnt = r_cnt + 1'b1;
                    if (n_cnt >= CNT_BITS'(ADDR_BITS)) begin
                        n_state = ST_TA1;
                    end
                end
                ST_TA1: begin
                    if (r_is_write) begin
                        if (i_bit) begin
                            n_state = ST_TA2;
                        end else begin
                            status  = STAT_TA_ERR;
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_drv   = addressed;
                        n_lvl   = 1'b0;
                        n_state = ST_TA2;
                    end
                end
                ST_TA2: begin
                    n_cnt = '0;
                    if (r_is_write) begin
                        if (!i_bit) begin
                            n_state = ST_WRITE;
                        end else begin
                            status  = STAT_TA_ERR;
                            n_state = ST_IDLE;
                        end
                    end else begin
                        if (addressed) begin
                            rreq   = 1'b1;
                            n_drv  = 1'b1;
                            n_lvl  = i_read_data[DATA_BITS-1];
                            n_data = {i_read_data[DATA_BITS-2:0], 1'b0};
                        end else begin
                            status = STAT_MISMATCH;
                            n_drv  = 1'b0;
                            n_lvl  = 1'b0;
                        end
                        n_cnt   = CNT_BITS'(1);
                        n_state = ST_READ;
                    end
                end
                ST_READ: begin
                    if (r_cnt >= CNT_BITS'(DATA_BITS)) begin
                        n_drv   = 1'b0;
                        n_lvl   = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        if (r_drv) begin
                            n_lvl  = r_data[DATA_BITS-1];
                            n_data = {r_data[DATA_BITS-2:0], 1'b0};
                        end
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                ST_WRITE: begin
                    n_data = {r_data[DATA_BITS-2:0], i_bit};
                    n_cnt  = r_cnt + 1'b1;
                    if (n_cnt >= CNT_BITS'(DATA_BITS)) begin
                        if (addressed) begin
                            wstb = 1'b1;
                        end else begin
                            status = STAT_MISMATCH;
                        end
                        n_state = ST_IDLE;
                    end
                end
                default: begin
                    n_state = i_bit ? ST_IDLE : ST_START;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_is_write <= 1'b0;
            r_data     <= '0;
            r_phy      <= '0;
            r_reg      <= '0;
            r_drv      <= 1'b0;
            r_lvl      <= 1'b0;
        end else if (i_accept) begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_is_write <= n_is_write;
            r_data     <= n_data;
            r_phy      <= n_phy;
            r_reg      <= n_reg;
            r_drv      <= n_drv;
            r_lvl      <= n_lvl;
        end
    end

    always_comb begin
        o_result.drive_enable     = n_drv;
        o_result.drive_bit        = n_lvl;
        o_result.read_request     = rreq;
        o_result.write_strobe     = wstb;
        o_result.register_address = n_reg;
        o_result.write_data       = n_data;
        o_result.status           = status;
    end

endmodule

### src/mdio22_checker.sv
// Port-level checks for mdio_clause22_slave, bound to the top level.
// Depends only on the top level's ports.
module mdio22_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result word changed or was dropped.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[0] && m_axis_tdata[26:25] == 2'd0)
        else $error("Read request without driving the line or with an error status.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[0] && !m_axis_tdata[2]
            && m_axis_tdata[26:25] == 2'd0)
        else $error("Write strobe while driving, with a read request or an error.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
        else $error("Drive level high while the line is released.");

endmodule

bind mdio_clause22_slave mdio22_checker u_mdio22_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
